/* hdl/tds_pkg.sv */
package tds_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_DOM  = 2'd1;
    localparam logic [1:0] ST_ZERO_PIV = 2'd2;
    localparam logic [1:0] ST_TOO_FEW  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] sub_diag;
        logic signed [DATA_W-1:0] main_diag;
        logic signed [DATA_W-1:0] super_diag;
        logic signed [DATA_W-1:0] rhs;
        logic                     last_row;
    } row_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] solution_value;
        logic [IDX_W-1:0]         row_index;
        logic                     last_result;
        logic [1:0]               status;
    } sol_out_t;

    // datapath operations issued by the controller
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1; // latch row, check dominance
    localparam logic [2:0] OP_PIVOT = 3'd2; // form pivot and numerator
    localparam logic [2:0] OP_DIVA  = 3'd3; // start alpha quotient
    localparam logic [2:0] OP_DIVB  = 3'd4; // start beta quotient
    localparam logic [2:0] OP_BREAD = 3'd5; // read store for back step
    localparam logic [2:0] OP_BSTEP = 3'd6; // back substitution update

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             last;
        logic             wr_alpha;
        logic             wr_beta;
        logic             init_back;
    } tds_cmd_t;

    typedef struct packed {
        logic not_dom;
        logic zero_piv;
        logic div_busy;
        logic div_done;
    } tds_sts_t;

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [64:0] v);
        logic signed [64:0] mx;
        logic signed [64:0] mn;
        mx = 65'sd2147483647;
        mn = -65'sd2147483648;
        if (v > mx) begin
            return 32'sh7fffffff;
        end else if (v < mn) begin
            return 32'sh80000000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

/* hdl/tds_div.sv */
module tds_div #(
    parameter int FRAC_BITS = tds_pkg::DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [tds_pkg::DATA_W:0]   num,
    input  logic signed [tds_pkg::DATA_W-1:0] den,
    output logic                              busy,
    output logic                              done,
    output logic signed [tds_pkg::DATA_W-1:0] quo
);
    import tds_pkg::*;

    // numerator magnitude shifted by FRAC_BITS fits in 33+FRAC_BITS bits
    localparam int NW = DATA_W + 1 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]     rem_reg, rem_next;
    logic [NW-1:0]     q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NW-1:0]     nmag;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   rsh;
    logic signed [64:0] sq;

    // numerator magnitude at start
    always_comb begin
        logic [DATA_W:0] na;
        na   = num[DATA_W] ? (DATA_W+1)'(-num) : $unsigned(num);
        nmag = NW'(na) << FRAC_BITS;
    end

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rsh       = {rem_reg[DATA_W-1:0], q_reg[NW-1]};
        trial     = rsh - {1'b0, d_reg};
        if (start) begin
            rem_next  = '0;
            q_next    = nmag;
            d_next    = den[DATA_W-1] ? DATA_W'(-den) : den;
            neg_next  = num[DATA_W] ^ den[DATA_W-1];
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DATA_W]) begin
                rem_next = NW'(trial);
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = NW'(rsh);
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // sign and saturate
    always_comb begin
        sq  = neg_reg ? -$signed({1'b0, 64'(q_reg)}) : $signed({1'b0, 64'(q_reg)});
        quo = sat64(sq);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* hdl/tds_datapath.sv */
module tds_datapath #(
    parameter int MAX_ROWS  = tds_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = tds_pkg::DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tds_pkg::row_in_t                  row,
    input  tds_pkg::tds_cmd_t                 cmd,
    output tds_pkg::tds_sts_t                 sts,
    output logic signed [tds_pkg::DATA_W-1:0] back_val
);
    import tds_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);

    logic signed [DATA_W-1:0] alpha_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] beta_mem  [MAX_ROWS];
    logic signed [DATA_W-1:0] a_rd_reg, b_rd_reg;
    row_in_t                  row_reg;
    logic signed [DATA_W-1:0] piv_reg, num_reg, back_reg;
    logic signed [DATA_W-1:0] piv_next, num_next;
    logic                     not_dom_reg, zero_piv_reg;
    logic                     div_start;
    logic signed [DATA_W:0]   div_num;
    logic signed [DATA_W-1:0] div_q;
    logic                     div_busy, div_done;
    logic signed [DATA_W-1:0] mul_a, mul_b, mulq_r;
    logic signed [63:0]       prod;
    logic [AW-1:0]            widx, ridx;
    logic [AW-1:0]            idx_m1;
    logic [DATA_W:0]          abs_m, abs_s, abs_p;
    logic [DATA_W+1:0]        bound;

    assign widx   = cmd.idx[AW-1:0];
    assign idx_m1 = widx - 1'b1;
    // load step reads entry idx-1, back steps read entry idx
    assign ridx   = (cmd.op == OP_LOAD) ? idx_m1 : widx;

    // dominance magnitudes from the incoming row
    always_comb begin
        abs_m = row.main_diag[DATA_W-1] ? (DATA_W+1)'(-$signed({1'b1, row.main_diag}))
                                        : {1'b0, row.main_diag};
        abs_s = row.sub_diag[DATA_W-1] ? (DATA_W+1)'(-$signed({1'b1, row.sub_diag}))
                                       : {1'b0, row.sub_diag};
        abs_p = row.super_diag[DATA_W-1] ? (DATA_W+1)'(-$signed({1'b1, row.super_diag}))
                                         : {1'b0, row.super_diag};
        bound = (cmd.first ? '0 : (DATA_W+2)'(abs_s)) + (cmd.last ? '0 : (DATA_W+2)'(abs_p));
    end

    // shared fractional multiplier, floor rounding
    always_comb begin
        if (cmd.op == OP_BSTEP) begin
            mul_a = a_rd_reg;
            mul_b = back_reg;
        end else begin
            mul_a = row_reg.sub_diag;
            mul_b = (cmd.wr_alpha) ? a_rd_reg : b_rd_reg;
        end
        prod   = 64'(mul_a) * 64'(mul_b);
        mulq_r = sat64(65'(prod >>> FRAC_BITS));
    end

    // pivot and numerator are formed over the pivot op: wr_alpha selects alpha product
    always_comb begin
        piv_next = piv_reg;
        num_next = num_reg;
        if (cmd.op == OP_PIVOT) begin
            if (cmd.wr_alpha) begin
                piv_next = cmd.first ? row_reg.main_diag
                    : sat64(65'(row_reg.main_diag) + 65'(mulq_r));
            end else begin
                num_next = cmd.first ? row_reg.rhs
                    : sat64(65'(row_reg.rhs) - 65'(mulq_r));
            end
        end
    end

    // negated super-diagonal keeps its full magnitude
    assign div_start = (cmd.op == OP_DIVA) || (cmd.op == OP_DIVB);
    assign div_num   = (cmd.op == OP_DIVA) ? -((DATA_W+1)'(row_reg.super_diag))
                                           : (DATA_W+1)'(num_reg);

    tds_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (piv_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_q)
    );

    // coefficient stores
    always_ff @(posedge aclk) begin
        if (cmd.wr_alpha && cmd.op == OP_NONE) begin
            alpha_mem[widx] <= cmd.last ? '0 : div_q;
        end
        if (cmd.wr_beta && cmd.op == OP_NONE) begin
            beta_mem[widx] <= div_q;
        end
        if (cmd.op == OP_LOAD || cmd.op == OP_BREAD) begin
            a_rd_reg <= alpha_mem[ridx];
            b_rd_reg <= beta_mem[ridx];
        end
    end

    // row latch, flags and back value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            not_dom_reg  <= 1'b0;
            zero_piv_reg <= 1'b0;
            back_reg     <= '0;
        end else begin
            if (cmd.op == OP_LOAD) begin
                not_dom_reg <= (DATA_W+2)'(abs_m) < bound;
            end
            if (cmd.op == OP_PIVOT && cmd.wr_alpha) begin
                zero_piv_reg <= (piv_next == '0);
            end
            if (cmd.op == OP_BREAD && cmd.init_back) begin
                back_reg <= beta_mem[widx];
            end
            if (cmd.op == OP_BSTEP) begin
                back_reg <= sat64(65'(mulq_r) + 65'(b_rd_reg));
            end
        end
        if (cmd.op == OP_LOAD) begin
            row_reg <= row;
        end
        piv_reg <= piv_next;
        num_reg <= num_next;
    end

    assign sts.not_dom  = not_dom_reg;
    assign sts.zero_piv = zero_piv_reg;
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign back_val     = back_reg;

endmodule

/* hdl/tds_ctrl.sv */
module tds_ctrl #(
    parameter int MAX_ROWS = tds_pkg::DEF_MAX_ROWS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_last_row,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tds_pkg::sol_out_t                 m_data,
    output tds_pkg::tds_cmd_t                 cmd,
    input  tds_pkg::tds_sts_t                 sts,
    input  logic signed [tds_pkg::DATA_W-1:0] back_val
);
    import tds_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_PIVA   = 4'd2;
    localparam logic [3:0] S_PIVB   = 4'd3;
    localparam logic [3:0] S_DIVA   = 4'd4;
    localparam logic [3:0] S_WAITA  = 4'd5;
    localparam logic [3:0] S_DIVB   = 4'd6;
    localparam logic [3:0] S_WAITB  = 4'd7;
    localparam logic [3:0] S_ENDROW = 4'd8;
    localparam logic [3:0] S_BREAD  = 4'd9;
    localparam logic [3:0] S_BEMIT  = 4'd10;
    localparam logic [3:0] S_BSTEP  = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_WRA    = 4'd13;
    localparam logic [3:0] S_WRB    = 4'd14;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ROWS - 1);

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       err_reg, err_next;
    logic             last_reg, last_next;
    logic             skip_reg, skip_next;
    logic             mv_reg, mv_next;
    sol_out_t         out_reg, out_next;
    logic             in_last;

    assign in_last = s_last_row || (idx_reg == LAST_IDX);
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        skip_next  = skip_reg;
        mv_next    = mv_reg;
        out_next   = out_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.first  = (idx_reg == '0);
        cmd.last   = last_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                cmd.last = in_last;
                cmd.op   = OP_LOAD;
                if (s_valid) begin
                    last_next  = in_last;
                    skip_next  = (err_reg != ST_OK) || (in_last && idx_reg == '0);
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (skip_reg) begin
                    state_next = S_ENDROW;
                end else if (sts.not_dom) begin
                    err_next   = ST_NOT_DOM;
                    state_next = S_ENDROW;
                end else begin
                    state_next = S_PIVA;
                end
            end
            S_PIVA: begin
                cmd.op       = OP_PIVOT;
                cmd.wr_alpha = 1'b1;
                state_next   = S_PIVB;
            end
            S_PIVB: begin
                cmd.op = OP_PIVOT;
                if (sts.zero_piv) begin
                    err_next   = ST_ZERO_PIV;
                    state_next = S_ENDROW;
                end else begin
                    state_next = S_DIVA;
                end
            end
            S_DIVA: begin
                cmd.op     = OP_DIVA;
                state_next = S_WAITA;
            end
            S_WAITA: begin
                if (sts.div_done) begin
                    state_next = S_WRA;
                end
            end
            S_WRA: begin
                cmd.wr_alpha = 1'b1;
                state_next   = S_DIVB;
            end
            S_DIVB: begin
                cmd.op     = OP_DIVB;
                state_next = S_WAITB;
            end
            S_WAITB: begin
                if (sts.div_done) begin
                    state_next = S_WRB;
                end
            end
            S_WRB: begin
                cmd.wr_beta = 1'b1;
                state_next  = S_ENDROW;
            end
            S_ENDROW: begin
                if (!last_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_IDLE;
                end else if (idx_reg == '0 || err_reg != ST_OK) begin
                    if (!mv_reg || m_ready) begin
                        out_next.solution_value = '0;
                        out_next.row_index      = '0;
                        out_next.last_result    = 1'b1;
                        out_next.status         = (idx_reg == '0) ? ST_TOO_FEW : err_reg;
                        mv_next    = 1'b1;
                        idx_next   = '0;
                        err_next   = ST_OK;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_BREAD;
                end
            end
            S_BREAD: begin
                // first visit loads back value from beta, later ones fetch coefficients
                cmd.op        = OP_BREAD;
                cmd.init_back = last_reg;
                state_next    = last_reg ? S_EMIT : S_BSTEP;
            end
            S_BSTEP: begin
                cmd.op     = OP_BSTEP;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    out_next.solution_value = back_val;
                    out_next.row_index      = idx_reg;
                    out_next.last_result    = (idx_reg == '0);
                    out_next.status         = ST_OK;
                    mv_next   = 1'b1;
                    last_next = 1'b0;
                    if (idx_reg == '0) begin
                        err_next   = ST_OK;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_BREAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            err_reg   <= ST_OK;
            last_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
            skip_reg  <= skip_next;
            mv_reg    <= mv_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

endmodule

/* hdl/tridiagonal_system_solver.sv */
// channel  | ports                      | beat
// ---------+----------------------------+-----------------------------------
// input    | s_valid, s_ready, s_data   | one matrix row (row_in_t)
// result   | m_valid, m_ready, m_data   | one solution entry or error code
//
// a solved row runs the bit-serial divider twice (alpha then beta); a row skipped
// after an error bypasses the pivot and divide states
// back substitution emits results from the last row down to row 0 while m_ready stays high
// aresetn is synchronous, active low; stores need no clearing
// rows are taken only while the controller is idle; a held result stalls the sweep
module tridiagonal_system_solver #(
    parameter int MAX_ROWS  = tds_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = tds_pkg::DEF_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tds_pkg::row_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tds_pkg::sol_out_t m_data
);
    import tds_pkg::*;

    tds_cmd_t                 cmd;
    tds_sts_t                 sts;
    logic signed [DATA_W-1:0] back_val;

    // sequencing
    tds_ctrl #(
        .MAX_ROWS(MAX_ROWS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_last_row (s_data.last_row),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cmd        (cmd),
        .sts        (sts),
        .back_val   (back_val)
    );

    // arithmetic and coefficient stores
    tds_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .row      (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .back_val (back_val)
    );

endmodule
